[rtl/mst_pkg.sv]
// Package of shared constants, codes and controller types for the minimum-tracking stack.
package mst_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int OP_W        = 2;
  localparam int COUNT_OUT_W = 7;
  localparam int STATUS_W    = 2;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam op_t OP_PUSH = 2'd0;
  localparam op_t OP_POP  = 2'd1;
  localparam op_t OP_READ = 2'd2;

  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_POP_EMPTY = 2'd1;
  localparam status_t STATUS_PUSH_FULL = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic take;
    logic load_tops;
    logic emit;
  } mst_cmd_t;

  typedef struct packed {
    logic req_valid;
    logic out_free;
  } mst_stat_t;

endpackage

[rtl/mst_req_if.sv]
// Handshake interface for operation requests into the stack.
interface mst_req_if
  import mst_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

[rtl/mst_rsp_if.sv]
// Handshake interface for results out of the stack.
interface mst_rsp_if
  import mst_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] top_value;
  logic signed [DATA_W-1:0] min_value;
  logic [COUNT_OUT_W-1:0]   count;
  logic                     is_empty;
  logic [STATUS_W-1:0]      status;

  modport source (output valid, output top_value, output min_value, output count,
                  output is_empty, output status, input ready);
  modport sink   (input valid, input top_value, input min_value, input count,
                  input is_empty, input status, output ready);
endinterface

[rtl/min_tracking_stack.sv]
// Top level of the LIFO stack that reports its minimum with every transaction.
//
//   Channel | Direction | Carries
//   --------+-----------+---------------------------------------------------
//   req     | in        | op, value
//   rsp     | out       | top_value, min_value, count, is_empty, status
//
// Each request transaction steps through accept, a refill of each top from the
// RAM read of the entry below it, and the load of the result register. The refill
// step is there because the stack RAMs have registered read data.
// Reset clears both counts and the result valid flag; stack contents are not cleared.
// A new request is taken while an earlier result still waits; a stalled rsp
// holds the block in its result cycle until the result register frees up.
module min_tracking_stack
  import mst_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  mst_req_if.sink   req,
  mst_rsp_if.source rsp
);

  mst_cmd_t  cmd;
  mst_stat_t stat;

  mst_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  mst_datapath u_datapath (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .cmd  (cmd),
    .stat (stat)
  );

endmodule

[rtl/mst_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/mst_ctrl.sv]
// Controller state machine sequencing accept, top refill and result hand-off.
module mst_ctrl
  import mst_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  mst_stat_t stat,
  output mst_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.take = 1'b1;
        if (stat.req_valid) begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.load_tops = 1'b1;
        state_next    = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/mst_datapath.sv]
// Datapath with both stacks, cached tops, counters and the result register.
module mst_datapath
  import mst_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  mst_req_if.sink   req,
  mst_rsp_if.source rsp,
  input  mst_cmd_t  cmd,
  output mst_stat_t stat
);

  logic [CNT_W-1:0]         main_count;
  logic [CNT_W-1:0]         min_count;
  logic signed [DATA_W-1:0] main_top;
  logic signed [DATA_W-1:0] min_top;
  status_t                  status_r;
  logic                     pop_main;
  logic                     pop_min;

  logic                     accept;
  logic                     is_push;
  logic                     is_pop;
  logic                     main_full;
  logic                     push_ok;
  logic                     push_min;
  logic                     pop_ok;
  logic                     pop_min_hit;
  logic [DATA_W-1:0]        main_rdata;
  logic [DATA_W-1:0]        min_rdata;
  logic [ADDR_W-1:0]        main_raddr;
  logic [ADDR_W-1:0]        min_raddr;

  logic                     out_valid;
  logic signed [DATA_W-1:0] out_top;
  logic signed [DATA_W-1:0] out_min;
  logic [COUNT_OUT_W-1:0]   out_count;
  logic                     out_empty;
  status_t                  out_status;

  assign req.ready      = cmd.take;
  assign accept         = req.valid & cmd.take;
  assign is_push        = (req.op == OP_PUSH);
  assign is_pop         = (req.op == OP_POP);
  assign main_full      = (main_count == CNT_W'(STACK_DEPTH));
  assign push_ok        = is_push & ~main_full;
  assign push_min       = push_ok & (min_count != '0 ? (req.value <= min_top) : 1'b1)
                          & (min_count != CNT_W'(STACK_DEPTH));
  assign pop_ok         = is_pop & (main_count != '0);
  assign pop_min_hit    = pop_ok & (min_count != '0) & (main_top == min_top);

  // The entry below each top is read ahead so that a pop can refill the top.
  assign main_raddr     = ADDR_W'(main_count - CNT_W'(2));
  assign min_raddr      = ADDR_W'(min_count - CNT_W'(2));

  assign stat.req_valid = req.valid;
  assign stat.out_free  = ~out_valid | rsp.ready;

  mst_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_main_ram (
    .clk   (clk),
    .we    (accept & push_ok),
    .waddr (ADDR_W'(main_count)),
    .wdata (req.value),
    .raddr (main_raddr),
    .rdata (main_rdata)
  );

  mst_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_min_ram (
    .clk   (clk),
    .we    (accept & push_min),
    .waddr (ADDR_W'(min_count)),
    .wdata (req.value),
    .raddr (min_raddr),
    .rdata (min_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      main_count <= '0;
      min_count  <= '0;
      pop_main   <= 1'b0;
      pop_min    <= 1'b0;
    end else if (accept) begin
      pop_main <= pop_ok;
      pop_min  <= pop_min_hit;
      if (push_ok) begin
        main_count <= main_count + CNT_W'(1);
      end else if (pop_ok) begin
        main_count <= main_count - CNT_W'(1);
      end
      if (push_min) begin
        min_count <= min_count + CNT_W'(1);
      end else if (pop_min_hit) begin
        min_count <= min_count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (push_ok) begin
        main_top <= req.value;
      end
      if (push_min) begin
        min_top <= req.value;
      end
      if (is_push && main_full) begin
        status_r <= STATUS_PUSH_FULL;
      end else if (is_pop && main_count == '0) begin
        status_r <= STATUS_POP_EMPTY;
      end else begin
        status_r <= STATUS_OK;
      end
    end
    if (cmd.load_tops) begin
      if (pop_main) begin
        main_top <= main_rdata;
      end
      if (pop_min) begin
        min_top <= min_rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_top    <= (main_count != '0) ? main_top : '0;
      out_min    <= (main_count != '0 && min_count != '0) ? min_top : '0;
      out_count  <= COUNT_OUT_W'(main_count);
      out_empty  <= (main_count == '0);
      out_status <= status_r;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.top_value = out_top;
  assign rsp.min_value = out_min;
  assign rsp.count     = out_count;
  assign rsp.is_empty  = out_empty;
  assign rsp.status    = out_status;

endmodule

[verif/min_stack_checker.sv]
// Checker for the minimum-tracking stack: tracks stack state from requests and checks every result.
`timescale 1ns / 1ps

module min_stack_checker
  import mst_pkg::*;
(
  input  logic clk,
  input  logic rst,
  mst_req_if   req,
  mst_rsp_if   rsp,
  output int   fail_count,
  output int   pending
);

  typedef struct {
    logic signed [DATA_W-1:0] top_value;
    logic signed [DATA_W-1:0] min_value;
    logic [COUNT_OUT_W-1:0]   count;
    logic                     is_empty;
    status_t                  status;
  } stack_view_t;

  logic signed [DATA_W-1:0] value_mem  [STACK_DEPTH];
  logic signed [DATA_W-1:0] minima_mem [STACK_DEPTH];
  int                       held;
  int                       minima_held;
  stack_view_t              views_due [$];

  initial fail_count = 0;

  task automatic report(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    fail_count++;
  endtask

  function automatic stack_view_t apply_op(op_t op, logic signed [DATA_W-1:0] v);
    stack_view_t view;
    status_t     st;
    logic        take_min;
    st = STATUS_OK;
    case (op)
      OP_PUSH: begin
        if (held >= STACK_DEPTH) begin
          st = STATUS_PUSH_FULL;
        end else begin
          value_mem[held] = v;
          held++;
          if (minima_held == 0) begin
            take_min = 1'b1;
          end else begin
            take_min = (v <= minima_mem[minima_held-1]);
          end
          if (take_min && minima_held < STACK_DEPTH) begin
            minima_mem[minima_held] = v;
            minima_held++;
          end
        end
      end
      OP_POP: begin
        if (held == 0) begin
          st = STATUS_POP_EMPTY;
        end else begin
          if (minima_held != 0) begin
            if (value_mem[held-1] == minima_mem[minima_held-1]) begin
              minima_held--;
            end
          end
          held--;
        end
      end
      default: begin
      end
    endcase
    view.top_value = (held != 0) ? value_mem[held-1] : '0;
    view.min_value = (held != 0 && minima_held != 0) ? minima_mem[minima_held-1] : '0;
    view.count     = held[COUNT_OUT_W-1:0];
    view.is_empty  = (held == 0);
    view.status    = st;
    return view;
  endfunction

  always @(posedge clk) begin
    stack_view_t want;
    if (rst) begin
      held        = 0;
      minima_held = 0;
      views_due.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (views_due.size() == 0) begin
          report($sformatf("unexpected result top %0d min %0d count %0d status %0d",
                           rsp.top_value, rsp.min_value, rsp.count, rsp.status));
        end else begin
          want = views_due.pop_front();
          if (rsp.top_value !== want.top_value)
            report($sformatf("top_value got %0d want %0d", rsp.top_value, want.top_value));
          if (rsp.min_value !== want.min_value)
            report($sformatf("min_value got %0d want %0d", rsp.min_value, want.min_value));
          if (rsp.count !== want.count)
            report($sformatf("count got %0d want %0d", rsp.count, want.count));
          if (rsp.is_empty !== want.is_empty)
            report($sformatf("is_empty got %0b want %0b", rsp.is_empty, want.is_empty));
          if (rsp.status !== want.status)
            report($sformatf("status got %0d want %0d", rsp.status, want.status));
        end
      end
      if (req.valid && req.ready) begin
        views_due.push_back(apply_op(req.op, req.value));
      end
    end
    pending = views_due.size();
  end

endmodule

[verif/tb_min_tracking_stack.sv]
// Testbench top for the minimum-tracking stack: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_min_tracking_stack;
  import mst_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 650;
  localparam op_t OP_SPARE    = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;

  mst_req_if req_ch ();
  mst_rsp_if rsp_ch ();

  min_tracking_stack DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  min_stack_checker stack_check (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom();
    if (r < 75) return $urandom_range(0, 8) - 4;
    if (r < 88) begin
      case ($urandom_range(0, 3))
        0: return 32'sh7FFF_FFFF;
        1: return 32'sh8000_0000;
        2: return 32'sh0000_0000;
        default: return -32'sd1;
      endcase
    end
    return $urandom_range(0, 2000) - 1000;
  endfunction

  // Fill phases lean hard on pushes so the stack reaches its full depth;
  // drain phases lean on pops so it empties and pops on an empty stack occur.
  function automatic op_t pick_op(int mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      0: return (r < 85) ? OP_PUSH : (r < 95) ? OP_POP : (r < 98) ? OP_READ : OP_SPARE;
      1: return (r < 80) ? OP_POP : (r < 93) ? OP_PUSH : (r < 97) ? OP_READ : OP_SPARE;
      default: return (r < 47) ? OP_PUSH : (r < 87) ? OP_POP : (r < 95) ? OP_READ : OP_SPARE;
    endcase
  endfunction

  task automatic send_op(op_t op, logic signed [DATA_W-1:0] v, int gap);
    req_ch.valid <= 1'b1;
    req_ch.op    <= op;
    req_ch.value <= v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    rsp_ch.ready <= 1'b0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      rsp_ch.ready <= 1'b1;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(30, 80) : $urandom_range(1, 6))
        @(posedge clk);
      if (pick_gap(1'b0) > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (pick_gap(1'b0) + 1) @(posedge clk);
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        idle = 0;
      else
        idle++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    int  mode;
    int  seg_len;
    int  sent;
    bit  quiet;
    req_ch.valid <= 1'b0;
    req_ch.op    <= OP_READ;
    req_ch.value <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Empty stack: read, pop on empty, spare code.
    send_op(OP_READ, 32'sd123, pick_gap(1'b0));
    send_op(OP_POP, -32'sd7, pick_gap(1'b0));
    send_op(OP_SPARE, 32'sh7FFF_FFFF, pick_gap(1'b0));
    // Extremes and an equal minimum pushed twice.
    send_op(OP_PUSH, 32'sd0, pick_gap(1'b0));
    send_op(OP_PUSH, 32'sh7FFF_FFFF, pick_gap(1'b0));
    send_op(OP_PUSH, 32'sh8000_0000, pick_gap(1'b0));
    send_op(OP_PUSH, 32'sh8000_0000, pick_gap(1'b0));
    send_op(OP_READ, 32'sd0, pick_gap(1'b0));
    send_op(OP_POP, 32'sd0, pick_gap(1'b0));
    send_op(OP_POP, 32'sd0, pick_gap(1'b0));
    send_op(OP_PUSH, -32'sd1, pick_gap(1'b0));
    send_op(OP_PUSH, 32'sd5, pick_gap(1'b0));
    send_op(OP_PUSH, -32'sd1, pick_gap(1'b0));
    send_op(OP_SPARE, 32'sd0, pick_gap(1'b0));
    repeat (5) send_op(OP_POP, $urandom(), pick_gap(1'b0));
    send_op(OP_POP, $urandom(), pick_gap(1'b0));

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mode    = $urandom_range(0, 3);
      quiet   = ($urandom_range(0, 3) == 0);
      seg_len = (mode == 0) ? $urandom_range(90, 140) : $urandom_range(20, 120);
      if (seg_len > RANDOM_ITEMS - sent)
        seg_len = RANDOM_ITEMS - sent;
      repeat (seg_len) begin
        send_op(pick_op(mode), pick_value(), pick_gap(quiet));
        sent++;
      end
    end
    req_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
